/* design/dopi_pkg.sv */
package dopi_pkg;

    localparam int KEY_W   = 17;
    localparam int COORD_W = 48;
    localparam int SNAP_W  = 15;
    localparam int BLEND_W = 17;
    localparam int NUM_W   = 36;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_INTERP = 2'd2;

    localparam logic [BLEND_W-1:0] ALPHA_ONE  = 17'd65536;
    localparam logic [SNAP_W-1:0]  SNAP_RESET = 15'd32;
    localparam logic [NUM_W-1:0]   HALF_Q16   = 36'd32768;

    localparam logic CFG_SNAP_INDEX = 1'b0;

    typedef struct packed {
        logic [1:0]          operation;
        logic [16:0]         blend;
        logic [15:0]         op_tag;
        logic                op_kind;
        logic signed [15:0]  pos_x;
        logic signed [15:0]  pos_y;
        logic signed [15:0]  line_len;
    } dopi_in_t;

    typedef struct packed {
        logic signed [15:0]  out_x;
        logic signed [15:0]  out_y;
        logic signed [15:0]  out_len;
        logic                blended;
        logic                status;
    } dopi_out_t;

endpackage

/* design/draw_op_position_interpolator_unit.sv */
// Clear, load and unused codes go from idle straight to the finish state.
// Interpolate, while the history has room, makes one pass over the history
// memory, a search of the previous-frame memory, a jump check, then a shared blend unit.
// One item is in work at a time; a new item is taken only once the result is registered.
// Reset (synchronous, active low): fills zero, blend 65536, snap_distance 32;
// table memories are not cleared.
module draw_op_position_interpolator_unit
    import dopi_pkg::*;
#(
    parameter int MAX_ENTRIES = 128
)(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  dopi_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output dopi_out_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int FILL_W = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W = $clog2(MAX_ENTRIES);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_ENTRIES);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CNT   = 3'd1;
    localparam logic [2:0] ST_SRCH  = 3'd2;
    localparam logic [2:0] ST_JCHK  = 3'd3;
    localparam logic [2:0] ST_BLEND = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    logic [KEY_W+COORD_W-1:0] prev_mem [MAX_ENTRIES];
    logic [KEY_W-1:0]         cur_mem  [MAX_ENTRIES];
    logic [KEY_W+COORD_W-1:0] prev_rd_reg;
    logic [KEY_W-1:0]         cur_rd_reg;

    logic [2:0]          state_reg;
    logic [FILL_W-1:0]   prev_fill_reg;
    logic [FILL_W-1:0]   cur_fill_reg;
    logic [FILL_W-1:0]   addr_reg;
    logic [FILL_W-1:0]   k_reg;
    logic                rd_vld_reg;
    logic [BLEND_W-1:0]  blend_reg;
    logic [SNAP_W-1:0]   snap_reg;
    logic                rec_reg;
    logic [1:0]          iss_reg;
    logic [1:0]          col_reg;
    logic                m_valid_reg;

    dopi_in_t            in_reg;
    dopi_out_t           m_data_reg;
    logic [COORD_W-1:0]  pc_reg;
    logic signed [15:0]  rx_reg, ry_reg, rn_reg;
    logic                rb_reg, rs_reg;

    logic [KEY_W-1:0]    in_key;
    logic [KEY_W-1:0]    acc_key;
    logic                accept;
    logic                out_free;
    logic                cfg_wr;
    logic                interp_go;
    logic                cnt_match;
    logic                srch_match;
    logic                prev_we;
    logic                cur_we;
    logic [1:0]          ncoord;
    logic signed [15:0]  px, py, pn;
    logic                jx, jy, jn;
    logic                bl_in_vld;
    logic signed [15:0]  bl_from, bl_to;
    logic                bl_out_vld;
    logic signed [15:0]  bl_res;

    function automatic logic jump(input logic signed [15:0] a, input logic signed [15:0] b,
                                  input logic [SNAP_W-1:0] snap);
        logic signed [17:0] d;
        logic signed [17:0] s;
        d = 18'(b) - 18'(a);
        s = $signed({3'b000, snap});
        return (d > s) || (d < -s);
    endfunction

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == CFG_SNAP_INDEX) ? 32'(snap_reg) : 32'd0;

    assign acc_key  = {s_data.op_tag, s_data.op_kind};
    assign in_key   = {in_reg.op_tag, in_reg.op_kind};

    assign interp_go = (s_data.operation == OP_INTERP) && (cur_fill_reg < FILL_MAX);

    assign cnt_match  = rd_vld_reg && (cur_rd_reg == in_key);
    assign srch_match = rd_vld_reg && (prev_rd_reg[KEY_W+COORD_W-1:COORD_W] == in_key);

    assign prev_we = accept && (s_data.operation == OP_LOAD) && (prev_fill_reg < FILL_MAX);
    assign cur_we  = (state_reg == ST_FIN) && out_free && rec_reg;

    assign px = pc_reg[47:32];
    assign py = pc_reg[31:16];
    assign pn = pc_reg[15:0];
    assign jx = jump(px, in_reg.pos_x, snap_reg);
    assign jy = jump(py, in_reg.pos_y, snap_reg);
    assign jn = in_reg.op_kind && jump(pn, in_reg.line_len, snap_reg);
    assign ncoord = in_reg.op_kind ? 2'd3 : 2'd2;

    assign bl_in_vld = (state_reg == ST_BLEND) && (iss_reg < ncoord);

    always_comb begin
        case (iss_reg)
            2'd0: begin
                bl_from = px;
                bl_to   = in_reg.pos_x;
            end
            2'd1: begin
                bl_from = py;
                bl_to   = in_reg.pos_y;
            end
            default: begin
                bl_from = pn;
                bl_to   = in_reg.line_len;
            end
        endcase
    end

    dopi_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (bl_in_vld),
        .from_val  (bl_from),
        .to_val    (bl_to),
        .alpha     (blend_reg),
        .out_valid (bl_out_vld),
        .result    (bl_res)
    );

    always_ff @(posedge aclk) begin
        if (prev_we) begin
            prev_mem[prev_fill_reg[ADDR_W-1:0]] <= {acc_key, s_data.pos_x, s_data.pos_y,
                                                    s_data.line_len};
        end
        prev_rd_reg <= prev_mem[addr_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (cur_we) begin
            cur_mem[cur_fill_reg[ADDR_W-1:0]] <= in_key;
        end
        cur_rd_reg <= cur_mem[addr_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            prev_fill_reg <= '0;
            cur_fill_reg  <= '0;
            addr_reg      <= '0;
            k_reg         <= '0;
            rd_vld_reg    <= 1'b0;
            blend_reg     <= ALPHA_ONE;
            snap_reg      <= SNAP_RESET;
            rec_reg       <= 1'b0;
            iss_reg       <= '0;
            col_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr && (paddr[2] == CFG_SNAP_INDEX)) begin
                snap_reg <= pwdata[SNAP_W-1:0];
            end
            if ((state_reg == ST_FIN) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        rec_reg    <= interp_go;
                        addr_reg   <= '0;
                        k_reg      <= '0;
                        rd_vld_reg <= 1'b0;
                        state_reg  <= interp_go ? ST_CNT : ST_FIN;
                        case (s_data.operation)
                            OP_CLEAR: begin
                                blend_reg     <= (s_data.blend > ALPHA_ONE) ? ALPHA_ONE
                                                                             : s_data.blend;
                                prev_fill_reg <= '0;
                                cur_fill_reg  <= '0;
                            end
                            OP_LOAD: begin
                                if (prev_we) begin
                                    prev_fill_reg <= prev_fill_reg + 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_CNT: begin
                    if (cnt_match) begin
                        k_reg <= k_reg + 1'b1;
                    end
                    if (addr_reg < cur_fill_reg) begin
                        addr_reg   <= addr_reg + 1'b1;
                        rd_vld_reg <= 1'b1;
                    end else begin
                        rd_vld_reg <= 1'b0;
                        if (!rd_vld_reg) begin
                            addr_reg  <= '0;
                            state_reg <= ST_SRCH;
                        end
                    end
                end
                ST_SRCH: begin
                    if (srch_match && (k_reg == '0)) begin
                        rd_vld_reg <= 1'b0;
                        state_reg  <= ST_JCHK;
                    end else begin
                        if (srch_match) begin
                            k_reg <= k_reg - 1'b1;
                        end
                        if (addr_reg < prev_fill_reg) begin
                            addr_reg   <= addr_reg + 1'b1;
                            rd_vld_reg <= 1'b1;
                        end else begin
                            rd_vld_reg <= 1'b0;
                            if (!rd_vld_reg) begin
                                state_reg <= ST_FIN;
                            end
                        end
                    end
                end
                ST_JCHK: begin
                    iss_reg <= '0;
                    col_reg <= '0;
                    if (jx || jy || jn) begin
                        state_reg <= ST_FIN;
                    end else begin
                        state_reg <= ST_BLEND;
                    end
                end
                ST_BLEND: begin
                    if (bl_in_vld) begin
                        iss_reg <= iss_reg + 1'b1;
                    end
                    if (bl_out_vld) begin
                        col_reg <= col_reg + 1'b1;
                        if (col_reg == ncoord - 2'd1) begin
                            state_reg <= ST_FIN;
                        end
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                        if (rec_reg) begin
                            cur_fill_reg <= cur_fill_reg + 1'b1;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_reg <= s_data;
            rb_reg <= 1'b0;
            rs_reg <= ((s_data.operation == OP_LOAD) && (prev_fill_reg >= FILL_MAX)) ||
                      ((s_data.operation == OP_INTERP) && (cur_fill_reg >= FILL_MAX));
            rx_reg <= (s_data.operation == OP_INTERP) ? s_data.pos_x : 16'sd0;
            ry_reg <= (s_data.operation == OP_INTERP) ? s_data.pos_y : 16'sd0;
            rn_reg <= (s_data.operation == OP_INTERP) ? s_data.line_len : 16'sd0;
        end
        if ((state_reg == ST_SRCH) && srch_match && (k_reg == '0)) begin
            pc_reg <= prev_rd_reg[COORD_W-1:0];
        end
        if ((state_reg == ST_BLEND) && bl_out_vld) begin
            case (col_reg)
                2'd0: rx_reg <= bl_res;
                2'd1: ry_reg <= bl_res;
                default: rn_reg <= bl_res;
            endcase
            rb_reg <= 1'b1;
        end
        if ((state_reg == ST_FIN) && out_free) begin
            m_data_reg.out_x   <= rx_reg;
            m_data_reg.out_y   <= ry_reg;
            m_data_reg.out_len <= rn_reg;
            m_data_reg.blended <= rb_reg;
            m_data_reg.status  <= rs_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* design/dopi_blend.sv */
module dopi_blend
    import dopi_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    input  logic signed [15:0]        from_val,
    input  logic signed [15:0]        to_val,
    input  logic        [BLEND_W-1:0] alpha,
    output logic                      out_valid,
    output logic signed [15:0]        result
);

    logic signed [16:0]      diff;
    logic signed [34:0]      prod;
    logic signed [NUM_W-1:0] num_next;
    logic signed [NUM_W-1:0] num_reg;
    logic                    num_vld_reg;
    logic        [NUM_W-1:0] mag;
    logic        [NUM_W-1:0] rnd;
    logic        [NUM_W-1:0] res_full;
    logic                    out_vld_reg;
    logic signed [15:0]      result_reg;

    assign diff     = 17'(to_val) - 17'(from_val);
    assign prod     = diff * $signed({1'b0, alpha});
    assign num_next = ($signed(NUM_W'(from_val)) <<< 16) + $signed(NUM_W'(prod));

    assign mag      = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
    assign rnd      = (mag + HALF_Q16) >> 16;
    assign res_full = num_reg[NUM_W-1] ? NUM_W'(-rnd) : rnd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            num_vld_reg <= in_valid;
            out_vld_reg <= num_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg    <= num_next;
        result_reg <= res_full[15:0];
    end

    assign out_valid = out_vld_reg;
    assign result    = result_reg;

endmodule

/* tb/sv/draw_op_position_interpolator_unit_tb.sv */
module draw_op_position_interpolator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dopi_pkg::*;

    localparam int TABLE_DEPTH = 128;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int PHASE_COUNT = 8;
    localparam int PHASE_ITEMS = 212;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [2:0] SNAP_ADDR = {CFG_SNAP_INDEX, 2'b00};

    typedef struct {
        dopi_in_t  item;
        bit        known;
        dopi_out_t want;
    } directed_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    dopi_in_t    s_data;
    logic        m_valid;
    logic        m_ready = 1'b0;
    dopi_out_t   m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic [16:0] prev_keys [TABLE_DEPTH];
    logic [47:0] prev_points [TABLE_DEPTH];
    logic [16:0] cur_keys [TABLE_DEPTH];
    int          prev_count;
    int          cur_count;
    logic [16:0] alpha_q16;
    logic [14:0] snap_reg;

    dopi_out_t     awaited_positions [$];
    dopi_out_t     due;
    directed_row_t directed_rows [22];
    int            fail_count = 0;
    int            driven_items = 0;
    int            cycle_count = 0;
    int            ready_hold = 0;
    bit            steady = 1'b0;

    draw_op_position_interpolator_unit #(.MAX_ENTRIES(TABLE_DEPTH)) u_top (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic bit too_far(int from, int to);
        int d;
        d = to - from;
        return d > int'(snap_reg) || d < -int'(snap_reg);
    endfunction

    // prev + (cur - prev) * alpha, rounded half away from zero
    function automatic logic [15:0] mix(int from, int to);
        longint num;
        longint mag;
        num = longint'(from) * longint'(ALPHA_ONE) + longint'(to - from) * longint'(alpha_q16);
        if (num >= 0) begin
            mag = (num + longint'(HALF_Q16)) >>> 16;
        end else begin
            mag = -((-num + longint'(HALF_Q16)) >>> 16);
        end
        return mag[15:0];
    endfunction

    function automatic dopi_out_t position_after(dopi_in_t it);
        dopi_out_t   r;
        logic [16:0] key;
        int          rank;
        int          hit;
        int          i;
        int          px;
        int          py;
        int          pn;
        r = '0;
        key = {it.op_tag, it.op_kind};
        hit = -1;
        case (it.operation)
            OP_CLEAR: begin
                alpha_q16 = (it.blend > ALPHA_ONE) ? ALPHA_ONE : it.blend;
                prev_count = 0;
                cur_count = 0;
            end
            OP_LOAD: begin
                if (prev_count >= TABLE_DEPTH) begin
                    r.status = 1'b1;
                end else begin
                    prev_keys[prev_count] = key;
                    prev_points[prev_count] = {it.pos_x, it.pos_y, it.line_len};
                    prev_count++;
                end
            end
            OP_INTERP: begin
                r.out_x = it.pos_x;
                r.out_y = it.pos_y;
                r.out_len = it.line_len;
                if (cur_count >= TABLE_DEPTH) begin
                    r.status = 1'b1;
                end else begin
                    rank = 0;
                    for (i = 0; i < cur_count; i++) begin
                        if (cur_keys[i] == key) rank++;
                    end
                    for (i = 0; i < prev_count && hit < 0; i++) begin
                        if (prev_keys[i] == key) begin
                            if (rank == 0) hit = i;
                            else rank--;
                        end
                    end
                    cur_keys[cur_count] = key;
                    cur_count++;
                    if (hit >= 0) begin
                        px = int'($signed(prev_points[hit][47:32]));
                        py = int'($signed(prev_points[hit][31:16]));
                        pn = int'($signed(prev_points[hit][15:0]));
                        if (!too_far(px, it.pos_x) && !too_far(py, it.pos_y) &&
                            (!it.op_kind || !too_far(pn, it.line_len))) begin
                            r.out_x = mix(px, it.pos_x);
                            r.out_y = mix(py, it.pos_y);
                            if (it.op_kind) r.out_len = mix(pn, it.line_len);
                            r.blended = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic directed_row_t row(logic [1:0] op, int bl, int tag, bit kind,
                                          int x, int y, int n, bit known,
                                          int wx = 0, int wy = 0, int wn = 0);
        directed_row_t r;
        r.item.operation = op;
        r.item.blend = bl[16:0];
        r.item.op_tag = tag[15:0];
        r.item.op_kind = kind;
        r.item.pos_x = x[15:0];
        r.item.pos_y = y[15:0];
        r.item.line_len = n[15:0];
        r.known = known;
        r.want = '0;
        r.want.out_x = wx[15:0];
        r.want.out_y = wy[15:0];
        r.want.out_len = wn[15:0];
        return r;
    endfunction

    function automatic dopi_in_t random_item();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return dopi_in_t'(raw[$bits(dopi_in_t)-1:0]);
    endfunction

    function automatic logic [16:0] pick_blend();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return ALPHA_ONE;
            2: return 17'($urandom_range(65537, 131071));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic int pause_len();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(4, 40);
    endfunction

    function automatic logic [15:0] nudge(logic signed [15:0] v);
        int d;
        int r;
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: d = int'(snap_reg) + int'($urandom_range(1, 2));
            2: d = int'(snap_reg);
            default: d = int'($urandom_range(0, 80)) - 40;
        endcase
        if ($urandom_range(0, 1) == 0) d = -d;
        r = int'(v) + d;
        return (r > 32767 || r < -32768) ? v : r[15:0];
    endfunction

    task automatic note_failure(string what);
        fail_count++;
        if (fail_count <= 10) $display("%s", what);
    endtask

    task automatic send(dopi_in_t it, bit known = 1'b0, dopi_out_t want = '0);
        int        gap;
        dopi_out_t predicted;
        gap = (steady || $urandom_range(0, 2) != 0) ? 0 : pause_len();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        predicted = position_after(it);
        awaited_positions.push_back(known ? want : predicted);
        if (it.operation != OP_UNUSED) driven_items++;
    endtask

    task automatic noise_item();
        dopi_in_t it;
        if ($urandom_range(0, 19) == 0) begin
            it = random_item();
            it.operation = OP_UNUSED;
            send(it);
        end
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (awaited_positions.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic apb_access(bit wr, logic [31:0] wdata, output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= SNAP_ADDR;
        pwdata <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_snap_reg();
        logic [31:0] rdata;
        apb_access(1'b0, '0, rdata);
        if (rdata !== {17'b0, snap_reg})
            note_failure($sformatf("snap_distance read: expected %0d, got %0d",
                                   snap_reg, rdata));
    endtask

    task automatic play_frame();
        dopi_in_t    it;
        dopi_in_t    pattern;
        dopi_in_t    loads [$];
        logic [15:0] tags [4];
        int          n_prev;
        int          n_cur;
        foreach (tags[i]) tags[i] = 16'($urandom);
        if ($urandom_range(0, 7) != 0) begin
            it = random_item();
            it.operation = OP_CLEAR;
            it.blend = pick_blend();
            send(it);
        end
        n_prev = ($urandom_range(0, 39) == 0) ? $urandom_range(120, 132) : $urandom_range(0, 10);
        n_cur = ($urandom_range(0, 39) == 0) ? $urandom_range(120, 132) : $urandom_range(0, 12);
        repeat (n_prev) begin
            it = random_item();
            it.operation = OP_LOAD;
            it.op_tag = tags[$urandom_range(0, 3)];
            loads.push_back(it);
            noise_item();
            send(it);
        end
        repeat (n_cur) begin
            it = random_item();
            it.operation = OP_INTERP;
            if (loads.size() != 0 && $urandom_range(0, 4) != 0) begin
                pattern = loads[$urandom_range(0, loads.size() - 1)];
                it.op_tag = pattern.op_tag;
                it.op_kind = pattern.op_kind;
                it.pos_x = nudge(pattern.pos_x);
                it.pos_y = nudge(pattern.pos_y);
                it.line_len = nudge(pattern.line_len);
            end else begin
                it.op_tag = tags[$urandom_range(0, 3)];
            end
            noise_item();
            send(it);
        end
    endtask

    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            m_ready <= 1'b0;
        end else if (!steady && $urandom_range(0, 7) == 0) begin
            ready_hold <= pause_len() - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (awaited_positions.size() == 0) begin
                note_failure($sformatf("unexpected result: x=%0d y=%0d len=%0d blended=%0b status=%0b",
                                       m_data.out_x, m_data.out_y, m_data.out_len,
                                       m_data.blended, m_data.status));
            end else begin
                due = awaited_positions.pop_front();
                if (m_data.out_x !== due.out_x || m_data.out_y !== due.out_y ||
                    m_data.out_len !== due.out_len || m_data.blended !== due.blended ||
                    m_data.status !== due.status)
                    note_failure($sformatf({"result mismatch: expected x=%0d y=%0d len=%0d ",
                                            "blended=%0b status=%0b, got x=%0d y=%0d len=%0d ",
                                            "blended=%0b status=%0b"},
                                           due.out_x, due.out_y, due.out_len, due.blended,
                                           due.status, m_data.out_x, m_data.out_y,
                                           m_data.out_len, m_data.blended, m_data.status));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        logic [14:0] snap_value;
        logic [31:0] wr_echo;
        int          start_items;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        prev_count = 0;
        cur_count = 0;
        alpha_q16 = ALPHA_ONE;
        snap_reg = SNAP_RESET;
        directed_rows = '{
            row(OP_INTERP, 0, 16'h1234, 1'b0, 5, -7, 3, 1'b1, 5, -7, 3),
            row(OP_UNUSED, 17'h1FFFF, 16'hFFFF, 1'b1, -1, -1, -1, 1'b1),
            row(OP_CLEAR, 17'h1FFFF, 0, 1'b0, 0, 0, 0, 1'b1),
            row(OP_LOAD, 0, 16'h0000, 1'b0, -32768, 32767, 0, 1'b1),
            row(OP_LOAD, 17'h1FFFF, 16'hFFFF, 1'b1, 32767, -32768, -32768, 1'b1),
            row(OP_LOAD, 0, 16'hFFFF, 1'b1, 100, 100, 10, 1'b1),
            row(OP_LOAD, 0, 16'hA5A5, 1'b0, 10, 20, 7, 1'b1),
            row(OP_INTERP, 0, 16'hFFFF, 1'b1, 32760, -32760, -32750, 1'b0),
            row(OP_INTERP, 0, 16'hFFFF, 1'b1, 120, 90, 40, 1'b0),
            row(OP_INTERP, 0, 16'hFFFF, 1'b1, 120, 90, 40, 1'b0),
            row(OP_INTERP, 0, 16'h0000, 1'b0, -32768, 32767, 12345, 1'b0),
            row(OP_INTERP, 0, 16'hA5A5, 1'b0, 50, 20, 7, 1'b0),
            row(OP_INTERP, 0, 16'hA5A5, 1'b1, 10, 20, 7, 1'b0),
            row(OP_CLEAR, 32768, 16'h5A5A, 1'b1, 32767, -1, 9, 1'b1),
            row(OP_LOAD, 0, 7, 1'b1, 0, 0, 0, 1'b1),
            row(OP_LOAD, 0, 7, 1'b1, -1, -3, 1, 1'b1),
            row(OP_INTERP, 0, 7, 1'b1, 1, -1, -1, 1'b0),
            row(OP_INTERP, 0, 7, 1'b1, 2, 0, 2, 1'b0),
            row(OP_CLEAR, 0, 0, 1'b0, 0, 0, 0, 1'b1),
            row(OP_LOAD, 0, 9, 1'b0, 3, 4, 0, 1'b1),
            row(OP_INTERP, 0, 9, 1'b0, 30, -20, 99, 1'b0),
            row(OP_INTERP, 0, 9, 1'b0, 3, 4, -32768, 1'b1, 3, 4, -32768)
        };
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        check_snap_reg();
        foreach (directed_rows[i])
            send(directed_rows[i].item, directed_rows[i].known, directed_rows[i].want);
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            settle();
            case (phase)
                0: snap_value = '0;
                1: snap_value = 15'h7FFF;
                2: snap_value = SNAP_RESET;
                default: snap_value = ($urandom_range(0, 1) == 0) ? 15'($urandom_range(0, 64))
                                                                   : 15'($urandom);
            endcase
            apb_access(1'b1, {17'b0, snap_value}, wr_echo);
            snap_reg = snap_value;
            check_snap_reg();
            steady = (phase % 3 == 2);
            start_items = driven_items;
            while (driven_items - start_items < PHASE_ITEMS) play_frame();
        end
        settle();
        repeat (32) @(posedge aclk);
        if (fail_count == 0 && awaited_positions.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
